@@ hw/rtl/tekd_pkg.sv @@
// types, constants and helper functions shared by the terminal key decoder
package tekd_pkg;

	localparam int PARAM_BITS = 8;

	typedef logic [PARAM_BITS-1:0] param_t;

	localparam param_t PARAM_MAX = '1;

	typedef enum logic [2:0] {
		PM_IDLE,
		PM_ESC,
		PM_CSI,
		PM_SS3,
		PM_P1,
		PM_SEMI,
		PM_P2
	} parse_mode_t;

	typedef enum logic [4:0] {
		K_PLAIN, K_ENTER, K_BKSP, K_ESC, K_UNK,
		K_UP, K_DOWN, K_RIGHT, K_LEFT, K_HOME, K_END,
		K_PGUP, K_PGDN, K_INS, K_DEL, K_F2,
		K_CTRL_UP, K_CTRL_DOWN, K_CTRL_RIGHT, K_CTRL_LEFT, K_CTRL_HOME, K_CTRL_END,
		K_SHIFT_UP, K_SHIFT_DOWN, K_SHIFT_RIGHT, K_SHIFT_LEFT,
		K_CS_UP, K_CS_DOWN, K_CS_RIGHT, K_CS_LEFT
	} key_code_t;

	localparam logic [7:0] CH_BS    = 8'd8;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_ESC   = 8'd27;
	localparam logic [7:0] CH_DEL   = 8'd127;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_F     = 8'h46;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_O     = 8'h4f;
	localparam logic [7:0] CH_LBRK  = 8'h5b;
	localparam logic [7:0] CH_TILDE = 8'h7e;

	localparam param_t MOD_SHIFT      = param_t'(2);
	localparam param_t MOD_CTRL       = param_t'(5);
	localparam param_t MOD_CTRL_SHIFT = param_t'(6);

	typedef struct packed {
		parse_mode_t mode;
		param_t      first_param;
		param_t      modifier_param;
	} dec_state_t;

	typedef struct packed {
		logic      valid;
		key_code_t code;
		logic [7:0] plain;
	} dec_result_t;

	function automatic param_t accumulate(input param_t acc, input logic [3:0] d);
		logic [PARAM_BITS+4:0] wide;
		logic [PARAM_BITS+4:0] v;
		wide = {5'b00000, acc};
		v = (wide << 3) + (wide << 1) + {{(PARAM_BITS+1){1'b0}}, d};
		if (v > {5'b00000, PARAM_MAX}) begin
			return PARAM_MAX;
		end
		return v[PARAM_BITS-1:0];
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

	function automatic logic is_arrow(input logic [7:0] b);
		return (b >= CH_A) && (b <= CH_D);
	endfunction

	function automatic key_code_t arrow_key(input key_code_t base, input logic [7:0] b);
		logic [1:0] ofs;
		ofs = 2'(b - CH_A);
		return key_code_t'(5'(base) + {3'b000, ofs});
	endfunction

	function automatic key_code_t letter_key(input logic [7:0] b);
		if (is_arrow(b)) begin
			return arrow_key(K_UP, b);
		end
		if (b == CH_H) begin
			return K_HOME;
		end
		if (b == CH_F) begin
			return K_END;
		end
		return K_UNK;
	endfunction

	function automatic key_code_t tilde_key(input param_t p);
		if (p == param_t'(1) || p == param_t'(7)) return K_HOME;
		if (p == param_t'(4) || p == param_t'(8)) return K_END;
		if (p == param_t'(5)) return K_PGUP;
		if (p == param_t'(6)) return K_PGDN;
		if (p == param_t'(2)) return K_INS;
		if (p == param_t'(3)) return K_DEL;
		if (p == param_t'(12)) return K_F2;
		return K_UNK;
	endfunction

	function automatic key_code_t modified_key(input param_t m, input logic [7:0] b);
		if (m == MOD_CTRL || m == MOD_CTRL_SHIFT) begin
			if (is_arrow(b)) begin
				return arrow_key((m == MOD_CTRL) ? K_CTRL_UP : K_CS_UP, b);
			end
			if (b == CH_H) return K_CTRL_HOME;
			if (b == CH_F) return K_CTRL_END;
		end else if (m == MOD_SHIFT) begin
			if (is_arrow(b)) return arrow_key(K_SHIFT_UP, b);
		end
		return K_UNK;
	endfunction

endpackage

@@ hw/rtl/terminal_escape_key_decoder_core.sv @@
// top level of the terminal escape sequence key decoder
// Takes one request per clock unless the output stalls: a keyboard byte in
// s_axis_tdata, or a timeout mark in s_axis_tuser when no byte came in the escape
// wait time. Each request passes an input register, the combinational parser logic
// and the output register; a new request is taken every cycle. A request that only
// advances a sequence (ESC, '[', 'O', digits, ';') or a timeout while idle gives no
// result. Only a stalled output register holds the input back.
module terminal_escape_key_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // byte_in
	input  logic        s_axis_tuser,  // timed_out
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // key_code[4:0], plain_byte[12:5], zero pad
);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  tmo_s1;
	logic                  advance;
	tekd_pkg::dec_state_t  state_q;
	tekd_pkg::dec_state_t  state_nxt;
	tekd_pkg::dec_result_t res;
	logic                  out_valid_q;
	tekd_pkg::key_code_t   code_q;
	logic [7:0]            plain_q;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			tmo_s1  <= s_axis_tuser;
		end
	end

	tekd_decode u_decode (
		.cur       (state_q),
		.byte_in   (byte_s1),
		.timed_out (tmo_s1),
		.nxt       (state_nxt),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode           <= tekd_pkg::PM_IDLE;
			state_q.first_param    <= '0;
			state_q.modifier_param <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.valid;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			code_q  <= res.code;
			plain_q <= res.plain;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, plain_q, code_q};

	a_idle_timeout_silent: assert property (@(posedge clk) disable iff (!arst_n)
		advance && tmo_s1 && state_q.mode == tekd_pkg::PM_IDLE |=> !m_axis_tvalid)
		else $error("timeout while idle produced a result");

	a_timeout_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		advance && tmo_s1 |=> state_q.mode == tekd_pkg::PM_IDLE)
		else $error("timeout did not return parser to idle");

	a_plain_only_for_plain: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && code_q != tekd_pkg::K_PLAIN |-> plain_q == 8'h00)
		else $error("plain byte set on a non-plain key");

endmodule

@@ hw/rtl/tekd_decode.sv @@
// next-state and result logic of the escape sequence parser
module tekd_decode (
	input  tekd_pkg::dec_state_t  cur,
	input  logic [7:0]            byte_in,
	input  logic                  timed_out,
	output tekd_pkg::dec_state_t  nxt,
	output tekd_pkg::dec_result_t res
);

	logic [3:0] digit;

	assign digit = 4'(byte_in - tekd_pkg::CH_ZERO);

	always_comb begin
		nxt = cur;
		if (timed_out) begin
			nxt.mode = tekd_pkg::PM_IDLE;
		end else begin
			nxt.mode = tekd_pkg::PM_IDLE;
			case (cur.mode)
				tekd_pkg::PM_ESC: begin
					if (byte_in == tekd_pkg::CH_LBRK) nxt.mode = tekd_pkg::PM_CSI;
					else if (byte_in == tekd_pkg::CH_O) nxt.mode = tekd_pkg::PM_SS3;
				end
				tekd_pkg::PM_CSI: begin
					if (tekd_pkg::is_digit(byte_in)) begin
						nxt.first_param = tekd_pkg::param_t'(digit);
						nxt.mode = tekd_pkg::PM_P1;
					end
				end
				tekd_pkg::PM_SS3: begin
					nxt.mode = tekd_pkg::PM_IDLE;
				end
				tekd_pkg::PM_P1: begin
					if (tekd_pkg::is_digit(byte_in)) begin
						nxt.first_param = tekd_pkg::accumulate(cur.first_param, digit);
						nxt.mode = tekd_pkg::PM_P1;
					end else if (byte_in == tekd_pkg::CH_SEMI) begin
						nxt.mode = tekd_pkg::PM_SEMI;
					end
				end
				tekd_pkg::PM_SEMI: begin
					if (tekd_pkg::is_digit(byte_in)) begin
						nxt.modifier_param = tekd_pkg::param_t'(digit);
						nxt.mode = tekd_pkg::PM_P2;
					end
				end
				tekd_pkg::PM_P2: begin
					if (tekd_pkg::is_digit(byte_in)) begin
						nxt.modifier_param = tekd_pkg::accumulate(cur.modifier_param, digit);
						nxt.mode = tekd_pkg::PM_P2;
					end
				end
				default: begin
					if (byte_in == tekd_pkg::CH_ESC) nxt.mode = tekd_pkg::PM_ESC;
				end
			endcase
		end
	end

	always_comb begin
		res.valid = 1'b1;
		res.code  = tekd_pkg::K_UNK;
		res.plain = 8'h00;
		if (timed_out) begin
			case (cur.mode)
				tekd_pkg::PM_IDLE: res.valid = 1'b0;
				tekd_pkg::PM_ESC, tekd_pkg::PM_CSI, tekd_pkg::PM_SS3: res.code = tekd_pkg::K_ESC;
				default: res.code = tekd_pkg::K_UNK;
			endcase
		end else begin
			case (cur.mode)
				tekd_pkg::PM_ESC: begin
					if (byte_in == tekd_pkg::CH_LBRK || byte_in == tekd_pkg::CH_O) res.valid = 1'b0;
				end
				tekd_pkg::PM_CSI: begin
					if (tekd_pkg::is_digit(byte_in)) res.valid = 1'b0;
					else res.code = tekd_pkg::letter_key(byte_in);
				end
				tekd_pkg::PM_SS3: begin
					res.code = tekd_pkg::letter_key(byte_in);
				end
				tekd_pkg::PM_P1: begin
					if (tekd_pkg::is_digit(byte_in) || byte_in == tekd_pkg::CH_SEMI) begin
						res.valid = 1'b0;
					end else if (byte_in == tekd_pkg::CH_TILDE) begin
						res.code = tekd_pkg::tilde_key(cur.first_param);
					end
				end
				tekd_pkg::PM_SEMI: begin
					if (tekd_pkg::is_digit(byte_in)) res.valid = 1'b0;
				end
				tekd_pkg::PM_P2: begin
					if (tekd_pkg::is_digit(byte_in)) res.valid = 1'b0;
					else res.code = tekd_pkg::modified_key(cur.modifier_param, byte_in);
				end
				default: begin
					if (byte_in == tekd_pkg::CH_CR || byte_in == tekd_pkg::CH_LF) begin
						res.code = tekd_pkg::K_ENTER;
					end else if (byte_in == tekd_pkg::CH_DEL || byte_in == tekd_pkg::CH_BS) begin
						res.code = tekd_pkg::K_BKSP;
					end else if (byte_in == tekd_pkg::CH_ESC) begin
						res.valid = 1'b0;
					end else begin
						res.code  = tekd_pkg::K_PLAIN;
						res.plain = byte_in;
					end
				end
			endcase
		end
	end

endmodule

@@ bench/terminal_escape_key_decoder_core_tb.sv @@
// testbench for the terminal key decoder: directed table and random key sequences vs. predictor
module terminal_escape_key_decoder_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tekd_pkg::*;

	localparam int RANDOM_ITEMS = 1050;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 8;

	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_NO_KEY,
		ROW_KEY
	} row_kind_e;

	typedef struct packed {
		logic [7:0] b;
		logic       tmo;
	} keystroke_t;

	typedef struct packed {
		key_code_t  code;
		logic [7:0] plain;
	} key_result_t;

	typedef struct packed {
		logic [7:0] b;
		logic       tmo;
		row_kind_e  kind;
		key_code_t  code;
		logic [7:0] plain;
	} stim_row_t;

	localparam int NUM_DIRECTED = 24;
	localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
		'{8'h00, 1'b1, ROW_NO_KEY, K_PLAIN, 8'h00},
		'{8'h00, 1'b0, ROW_KEY, K_PLAIN, 8'h00},
		'{8'hff, 1'b0, ROW_KEY, K_PLAIN, 8'hff},
		'{CH_CR, 1'b0, ROW_KEY, K_ENTER, 8'h00},
		'{CH_DEL, 1'b0, ROW_KEY, K_BKSP, 8'h00},
		'{CH_ESC, 1'b0, ROW_NO_KEY, K_PLAIN, 8'h00},
		'{8'ha5, 1'b1, ROW_KEY, K_ESC, 8'h00},
		'{CH_ESC, 1'b0, ROW_NO_KEY, K_PLAIN, 8'h00},
		'{8'h78, 1'b0, ROW_KEY, K_UNK, 8'h00},
		'{CH_ESC, 1'b0, ROW_NO_KEY, K_PLAIN, 8'h00},
		'{CH_O, 1'b0, ROW_NO_KEY, K_PLAIN, 8'h00},
		'{CH_H, 1'b0, ROW_PREDICT, K_PLAIN, 8'h00},
		'{CH_ESC, 1'b0, ROW_NO_KEY, K_PLAIN, 8'h00},
		'{CH_LBRK, 1'b0, ROW_NO_KEY, K_PLAIN, 8'h00},
		'{CH_ZERO + 8'd1, 1'b0, ROW_NO_KEY, K_PLAIN, 8'h00},
		'{CH_SEMI, 1'b0, ROW_NO_KEY, K_PLAIN, 8'h00},
		'{CH_ZERO + 8'd6, 1'b0, ROW_NO_KEY, K_PLAIN, 8'h00},
		'{CH_D, 1'b0, ROW_PREDICT, K_PLAIN, 8'h00},
		'{CH_ESC, 1'b0, ROW_NO_KEY, K_PLAIN, 8'h00},
		'{CH_LBRK, 1'b0, ROW_NO_KEY, K_PLAIN, 8'h00},
		'{CH_NINE, 1'b0, ROW_NO_KEY, K_PLAIN, 8'h00},
		'{CH_NINE, 1'b0, ROW_NO_KEY, K_PLAIN, 8'h00},
		'{CH_NINE, 1'b0, ROW_NO_KEY, K_PLAIN, 8'h00},
		'{CH_TILDE, 1'b0, ROW_PREDICT, K_PLAIN, 8'h00}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;  // byte_in
	logic        s_axis_tuser = 1'b0;   // timed_out
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;          // key_code[4:0], plain_byte[12:5], zero pad

	parse_mode_t dec_mode = PM_IDLE;
	param_t      dec_first = '0;
	param_t      dec_mod = '0;

	key_result_t pending_keys[$];
	keystroke_t  keystrokes[$];
	int          mismatches = 0;
	int          idle_cycles = 0;
	int          useful_items = 0;
	int unsigned send_run = 0;
	int unsigned ready_run = 0;
	int unsigned ready_stall = 0;

	terminal_escape_key_decoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #2 clk = ~clk;

	function automatic logic digit_char(input logic [7:0] ch);
		return ch >= CH_ZERO && ch <= CH_NINE;
	endfunction

	function automatic param_t push_digit(input param_t acc, input logic [7:0] ch);
		int unsigned v;
		v = int'(acc) * 10 + int'(ch - CH_ZERO);
		return (v > int'(PARAM_MAX)) ? PARAM_MAX : param_t'(v);
	endfunction

	function automatic key_code_t csi_final(input logic [7:0] ch, input key_code_t arrow_base,
			input key_code_t home_key, input key_code_t end_key);
		if (ch >= CH_A && ch <= CH_D) begin
			return key_code_t'(arrow_base + 5'(ch - CH_A));
		end
		if (ch == CH_H) return home_key;
		if (ch == CH_F) return end_key;
		return K_UNK;
	endfunction

	function automatic key_code_t tilde_final(input param_t p);
		case (int'(p))
			1, 7: return K_HOME;
			4, 8: return K_END;
			5: return K_PGUP;
			6: return K_PGDN;
			2: return K_INS;
			3: return K_DEL;
			12: return K_F2;
			default: return K_UNK;
		endcase
	endfunction

	function automatic key_code_t modifier_final(input param_t m, input logic [7:0] ch);
		if (m == MOD_CTRL) return csi_final(ch, K_CTRL_UP, K_CTRL_HOME, K_CTRL_END);
		if (m == MOD_CTRL_SHIFT) return csi_final(ch, K_CS_UP, K_CTRL_HOME, K_CTRL_END);
		if (m == MOD_SHIFT) return csi_final(ch, K_SHIFT_UP, K_UNK, K_UNK);
		return K_UNK;
	endfunction

	function automatic void decode_keystroke(input logic [7:0] b, input logic tmo,
			output logic produced, output key_result_t res);
		parse_mode_t mode;
		mode = dec_mode;
		produced = 1'b1;
		res.code = K_UNK;
		res.plain = 8'h00;
		if (tmo) begin
			if (mode == PM_IDLE) begin
				produced = 1'b0;
			end else begin
				res.code = (mode == PM_ESC || mode == PM_CSI || mode == PM_SS3) ? K_ESC : K_UNK;
				dec_mode = PM_IDLE;
			end
			return;
		end
		dec_mode = PM_IDLE;
		case (mode)
			PM_ESC: begin
				if (b == CH_LBRK) begin
					dec_mode = PM_CSI;
					produced = 1'b0;
				end else if (b == CH_O) begin
					dec_mode = PM_SS3;
					produced = 1'b0;
				end
			end
			PM_CSI: begin
				if (digit_char(b)) begin
					dec_first = param_t'(b - CH_ZERO);
					dec_mode = PM_P1;
					produced = 1'b0;
				end else begin
					res.code = csi_final(b, K_UP, K_HOME, K_END);
				end
			end
			PM_SS3: res.code = csi_final(b, K_UP, K_HOME, K_END);
			PM_P1: begin
				if (digit_char(b)) begin
					dec_first = push_digit(dec_first, b);
					dec_mode = PM_P1;
					produced = 1'b0;
				end else if (b == CH_SEMI) begin
					dec_mode = PM_SEMI;
					produced = 1'b0;
				end else if (b == CH_TILDE) begin
					res.code = tilde_final(dec_first);
				end
			end
			PM_SEMI: begin
				if (digit_char(b)) begin
					dec_mod = param_t'(b - CH_ZERO);
					dec_mode = PM_P2;
					produced = 1'b0;
				end
			end
			PM_P2: begin
				if (digit_char(b)) begin
					dec_mod = push_digit(dec_mod, b);
					dec_mode = PM_P2;
					produced = 1'b0;
				end else begin
					res.code = modifier_final(dec_mod, b);
				end
			end
			default: begin
				if (b == CH_CR || b == CH_LF) begin
					res.code = K_ENTER;
				end else if (b == CH_DEL || b == CH_BS) begin
					res.code = K_BKSP;
				end else if (b == CH_ESC) begin
					dec_mode = PM_ESC;
					produced = 1'b0;
				end else begin
					res.code = K_PLAIN;
					res.plain = b;
				end
			end
		endcase
	endfunction

	// mostly short gaps, a few long ones, and bursts with none
	function automatic int unsigned pick_gap(inout int unsigned run_left);
		int unsigned r;
		if (run_left > 0) begin
			run_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			run_left = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void queue_byte(input logic [7:0] b);
		keystrokes.push_back('{b, 1'b0});
	endfunction

	function automatic void queue_timeout();
		keystrokes.push_back('{8'($urandom_range(0, 255)), 1'b1});
	endfunction

	function automatic void queue_number(input int unsigned n);
		logic [7:0] digits[$];
		do begin
			digits.push_front(CH_ZERO + 8'(n % 10));
			n = n / 10;
		end while (n != 0);
		if ($urandom_range(0, 9) == 0) digits.push_front(CH_ZERO);
		foreach (digits[i]) queue_byte(digits[i]);
	endfunction

	function automatic int unsigned pick_first_param();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65) begin
			case ($urandom_range(0, 8))
				0: return 1;
				1: return 2;
				2: return 3;
				3: return 4;
				4: return 5;
				5: return 6;
				6: return 7;
				7: return 8;
				default: return 12;
			endcase
		end
		if (r < 85) return $urandom_range(0, 99);
		return $urandom_range(100, 999999);
	endfunction

	function automatic int unsigned pick_modifier();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 75) begin
			case ($urandom_range(0, 2))
				0: return 2;
				1: return 5;
				default: return 6;
			endcase
		end
		if (r < 92) return $urandom_range(0, 20);
		return $urandom_range(100, 99999);
	endfunction

	function automatic logic [7:0] pick_final();
		if ($urandom_range(0, 99) < 80) begin
			case ($urandom_range(0, 5))
				0: return CH_A;
				1: return CH_A + 8'd1;
				2: return CH_A + 8'd2;
				3: return CH_D;
				4: return CH_H;
				default: return CH_F;
			endcase
		end
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic void add_sequence();
		int unsigned r;
		int unsigned start;
		int unsigned cut;
		start = keystrokes.size();
		r = $urandom_range(0, 99);
		if (r < 24) begin
			queue_byte(8'($urandom_range(0, 255)));
		end else if (r < 30) begin
			queue_timeout();
		end else if (r < 34) begin
			queue_byte(CH_ESC);
			queue_byte(8'($urandom_range(0, 255)));
		end else if (r < 46) begin
			queue_byte(CH_ESC);
			queue_byte(CH_LBRK);
			queue_byte(pick_final());
		end else if (r < 56) begin
			queue_byte(CH_ESC);
			queue_byte(CH_O);
			queue_byte(pick_final());
		end else if (r < 74) begin
			queue_byte(CH_ESC);
			queue_byte(CH_LBRK);
			queue_number(pick_first_param());
			queue_byte(($urandom_range(0, 9) != 0) ? CH_TILDE : 8'($urandom_range(0, 255)));
		end else begin
			queue_byte(CH_ESC);
			queue_byte(CH_LBRK);
			queue_number(pick_first_param());
			queue_byte(CH_SEMI);
			queue_number(pick_modifier());
			queue_byte(pick_final());
		end
		// cut some sequences short with a timeout
		if (keystrokes.size() - start >= 2 && $urandom_range(0, 99) < 12) begin
			cut = $urandom_range(start + 1, keystrokes.size() - 1);
			while (keystrokes.size() > cut) void'(keystrokes.pop_back());
			queue_timeout();
		end
	endfunction

	task automatic send_keystroke(input keystroke_t k, input row_kind_e kind,
			input key_result_t typed);
		int unsigned gap;
		logic produced;
		key_result_t res;
		gap = pick_gap(send_run);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = k.b;
		s_axis_tuser = k.tmo;
		do @(posedge clk); while (!s_axis_tready);
		if (!(k.tmo && dec_mode == PM_IDLE)) useful_items++;
		decode_keystroke(k.b, k.tmo, produced, res);
		case (kind)
			ROW_PREDICT: if (produced) pending_keys.push_back(res);
			ROW_KEY: pending_keys.push_back(typed);
			default: ;
		endcase
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready = 1'b0;
		end else if (ready_stall > 0) begin
			m_axis_tready = 1'b0;
			ready_stall--;
		end else begin
			m_axis_tready = 1'b1;
			ready_stall = pick_gap(ready_run);
		end
	end

	always @(posedge clk) begin
		key_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_keys.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected key: expected none, got code %0d plain %02h",
					$time, m_axis_tdata[4:0], m_axis_tdata[12:5]);
			end else begin
				want = pending_keys.pop_front();
				if (m_axis_tdata[4:0] != want.code || m_axis_tdata[12:5] != want.plain ||
						m_axis_tdata[15:13] != 3'b000) begin
					mismatches++;
					$display("%0t: key mismatch: expected code %0d plain %02h pad 0,",
						$time, want.code, want.plain,
						" got code %0d plain %02h pad %0d",
						m_axis_tdata[4:0], m_axis_tdata[12:5], m_axis_tdata[15:13]);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: watchdog expired with %0d keys pending",
					$time, pending_keys.size());
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		keystroke_t k;
		logic paused;
		paused = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (DIRECTED[i]) begin
			send_keystroke('{DIRECTED[i].b, DIRECTED[i].tmo}, DIRECTED[i].kind,
				'{DIRECTED[i].code, DIRECTED[i].plain});
		end

		useful_items = 0;
		while (useful_items < RANDOM_ITEMS) begin
			if (keystrokes.size() == 0) add_sequence();
			k = keystrokes.pop_front();
			send_keystroke(k, ROW_PREDICT, '{K_PLAIN, 8'h00});
			// hold requests back once until every pending key is out
			if (!paused && useful_items >= RANDOM_ITEMS / 2) begin
				paused = 1'b1;
				s_axis_tvalid = 1'b0;
				while (pending_keys.size() != 0) @(negedge clk);
			end
		end
		s_axis_tvalid = 1'b0;

		while (pending_keys.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/tekd_pkg.sv
hw/rtl/tekd_decode.sv
hw/rtl/terminal_escape_key_decoder_core.sv
bench/terminal_escape_key_decoder_core_tb.sv
